@@ rtl/mdcs_pkg.sv @@
// Shared types, codes and defaults of the two-CPU feedback-queue scheduler.
`default_nettype none
package mdcs_pkg;

  localparam int MaxProcsDef  = 16;
  localparam int MaxBurstsDef = 8;
  localparam int QuantumDef   = 2;
  localparam int NumLevels    = 3;
  localparam logic [15:0] TimeMax = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_SLICE   = 3'd0,
    KIND_FINISH  = 3'd1,
    KIND_LOAD_OK = 3'd2,
    KIND_ERROR   = 3'd3,
    KIND_PENDING = 3'd4,
    KIND_DONE    = 3'd5
  } kind_e;

  typedef enum logic {
    ALU_ADD_SAT = 1'b0,
    ALU_SUB     = 1'b1
  } alu_op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_BOOST, ST_BMOVE, ST_BREAD, ST_BBLK,
    ST_REL, ST_RELB, ST_RIO, ST_RIO2, ST_RMARK, ST_RSCAN, ST_RPUSH, ST_RCMP,
    ST_ADMIT, ST_ASSIGN, ST_ASNRD, ST_JUMP, ST_JBLK, ST_STATUS
  } state_e;

  typedef struct packed {
    logic        op;
    logic [7:0]  pid;
    logic [15:0] arr;
    logic [15:0] len;
    logic        fin;
  } item_t;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  pid;
    logic [7:0]  inst;
    logic        cpu;
    logic [15:0] st;
    logic [15:0] en;
    logic        last;
  } emit_t;

endpackage
`default_nettype wire

@@ rtl/mdcs_alu.sv @@
// Shared time unit: saturating add and wrapping subtract on 16-bit times.
`default_nettype none
module mdcs_alu
  import mdcs_pkg::*;
(
  input  alu_op_e     op_i,
  input  logic [15:0] a_i,
  input  logic [15:0] b_i,
  output logic [15:0] res_o,
  output logic        ovf_o
);

  logic [16:0] sum;

  always_comb begin
    sum = {1'b0, a_i} + {1'b0, b_i};
    unique case (op_i)
      ALU_ADD_SAT: begin
        ovf_o = sum[16];
        res_o = sum[16] ? TimeMax : sum[15:0];
      end
      default: begin
        ovf_o = 1'b0;
        res_o = a_i - b_i;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/mdcs_seq.sv @@
// Scheduler sequencer: process tables, level queues, blocked list and CPUs.
`default_nettype none
module mdcs_seq
  import mdcs_pkg::*;
#(
  parameter int MAX_PROCS     = MaxProcsDef,
  parameter int MAX_BURSTS    = MaxBurstsDef,
  parameter int SLICE_QUANTUM = QuantumDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_acc_i,
  input  item_t       item_i,
  input  logic [15:0] boost_i,
  input  logic        emit_ok_i,
  output logic        ready_o,
  output emit_t       emit_o
);

  localparam int PW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW  = $clog2(MAX_PROCS + 1);
  localparam int BCW = $clog2(MAX_BURSTS + 1);
  localparam int QW  = $clog2(SLICE_QUANTUM + 1);
  localparam int BD  = MAX_PROCS * MAX_BURSTS;
  localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
  localparam int FD  = NumLevels * MAX_PROCS;
  localparam int FAW = $clog2(FD);

  state_e state_q, state_d;

  // process tables
  logic [7:0]     pid_q  [MAX_PROCS];
  logic [15:0]    arr_q  [MAX_PROCS];
  logic [BCW-1:0] bcnt_q [MAX_PROCS];
  logic [BCW-1:0] bpos_q [MAX_PROCS];
  logic [15:0]    rem_q  [MAX_PROCS];
  logic [1:0]     lvl_q  [MAX_PROCS];
  logic [15:0]    iod_q  [MAX_PROCS];
  logic [7:0]     slc_q  [MAX_PROCS];
  logic [PW-1:0]  blk_q  [MAX_PROCS];
  logic [MAX_PROCS-1:0] rdy_q, gone_q;

  logic [15:0]    bmem [BD];
  logic [15:0]    brd_q;
  logic [PW-1:0]  fmem [FD];
  logic [PW-1:0]  frd_q;

  logic [PW-1:0]  head_q [NumLevels];
  logic [CW-1:0]  cnt_q  [NumLevels];
  logic [CW-1:0]  bc_q;

  logic [1:0]     busy_q;
  logic [PW-1:0]  own_q [2];
  logic [15:0]    end_q [2];
  logic [QW-1:0]  len_q [2];

  logic [15:0]    now_q, lastb_q, t0_q, tmin_q;
  logic [CW-1:0]  nxt_q, pc_q, done_q, i_q, j_q, best_q;
  logic [7:0]     bestpid_q;
  logic           open_q, ovf_q, found_q, c_q;
  logic [1:0]     lv_q;
  logic [PW-1:0]  cur_q;
  item_t          it_q;

  // shared unit
  alu_op_e     alu_op;
  logic [15:0] alu_a, alu_b, alu_res;
  logic        alu_ovf;

  mdcs_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res),
    .ovf_o (alu_ovf)
  );

  function automatic logic [PW-1:0] tail_of(logic [PW-1:0] h, logic [CW-1:0] n);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(n);
    if (s >= (CW+1)'(MAX_PROCS)) s = s - (CW+1)'(MAX_PROCS);
    return PW'(s);
  endfunction

  function automatic logic [PW-1:0] head_inc(logic [PW-1:0] h);
    return (h == PW'(MAX_PROCS - 1)) ? '0 : PW'(h + PW'(1));
  endfunction

  function automatic logic [FAW-1:0] faddr(logic [1:0] lv, logic [PW-1:0] idx);
    return FAW'(32'(lv) * MAX_PROCS + 32'(idx));
  endfunction

  function automatic logic [BAW-1:0] baddr(logic [PW-1:0] p, logic [BCW:0] pos);
    return BAW'(32'(p) * MAX_BURSTS + 32'(pos));
  endfunction

  // shared views
  logic [PW-1:0]  ld_pi, prev_i, blk_i, nxt_i, rel_own, asn_p, best_p;
  logic [BCW-1:0] ld_c;
  logic           ld_ok, rel_skip, rem_zero, has_io, has_next, asn_any;
  logic [BCW:0]   pos1, pos2;
  logic [1:0]     new_lvl, asn_lv;
  logic [QW-1:0]  run;
  logic [7:0]     slc_new;

  assign ld_pi   = PW'(pc_q);
  assign prev_i  = PW'(pc_q - CW'(1));
  assign ld_c    = bcnt_q[ld_pi];
  assign blk_i   = blk_q[PW'(i_q)];
  assign nxt_i   = PW'(nxt_q);
  assign rel_own = own_q[c_q];
  assign best_p  = blk_q[PW'(best_q)];
  assign asn_p   = frd_q;

  always_comb begin
    if (it_q.len == '0) begin
      ld_ok = 1'b0;
    end else if (open_q) begin
      ld_ok = (ld_c < BCW'(MAX_BURSTS)) && !(it_q.fin && ld_c[0]);
    end else begin
      ld_ok = (pc_q < CW'(MAX_PROCS)) &&
              !((pc_q != '0) && (it_q.arr < arr_q[prev_i]));
    end
  end

  assign rel_skip = !busy_q[c_q] || (end_q[c_q] > now_q);
  assign rem_zero = (rem_q[cur_q] == '0);
  assign pos1     = (BCW+1)'(bpos_q[cur_q]) + (BCW+1)'(1);
  assign pos2     = pos1 + (BCW+1)'(1);
  assign has_io   = pos1 < (BCW+1)'(bcnt_q[cur_q]);
  assign has_next = pos2 < (BCW+1)'(bcnt_q[cur_q]);
  assign new_lvl  = (lvl_q[cur_q] < 2'd2) ? lvl_q[cur_q] + 2'd1 : lvl_q[cur_q];
  assign asn_any  = (cnt_q[0] != '0) || (cnt_q[1] != '0) || (cnt_q[2] != '0);
  assign asn_lv   = (cnt_q[0] != '0) ? 2'd0 : ((cnt_q[1] != '0) ? 2'd1 : 2'd2);
  assign run      = (rem_q[asn_p] < 16'(SLICE_QUANTUM)) ? QW'(rem_q[asn_p])
                                                         : QW'(SLICE_QUANTUM);
  assign slc_new  = (slc_q[asn_p] == 8'hFF) ? 8'hFF : slc_q[asn_p] + 8'd1;

  // queue and memory port controls
  logic          push_en, pop_en, fre, bre, bwe;
  logic [1:0]    push_lv, pop_lv;
  logic [PW-1:0] push_p;
  logic [FAW-1:0] fra;
  logic [BAW-1:0] bra, bwa;

  assign ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    emit_o  = '0;
    alu_op  = ALU_SUB;
    alu_a   = now_q;
    alu_b   = lastb_q;
    push_en = 1'b0;
    push_lv = 2'd0;
    push_p  = '0;
    pop_en  = 1'b0;
    pop_lv  = lv_q;
    fre     = 1'b0;
    fra     = faddr(lv_q, head_q[lv_q]);
    bre     = 1'b0;
    bra     = baddr(cur_q, pos1);
    bwe     = 1'b0;
    bwa     = baddr(ld_pi, open_q ? (BCW+1)'(ld_c) : '0);
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc_i) begin
          if (!item_i.op) state_d = ST_LOAD;
          else state_d = (done_q < pc_q) ? ST_BOOST : ST_STATUS;
        end
      end
      ST_LOAD: begin
        emit_o.valid = 1'b1;
        emit_o.kind  = ld_ok ? KIND_LOAD_OK : KIND_ERROR;
        emit_o.pid   = it_q.pid;
        emit_o.last  = 1'b1;
        bwe = emit_ok_i && ld_ok;
        if (emit_ok_i) state_d = ST_IDLE;
      end
      ST_BOOST: begin
        if ((boost_i != '0) && (now_q != '0) && (alu_res >= boost_i)) state_d = ST_BMOVE;
        else state_d = ST_REL;
      end
      ST_BMOVE: begin
        if (cnt_q[lv_q] == '0) begin
          if (lv_q == 2'd2) state_d = ST_BBLK;
        end else begin
          fre = 1'b1;
          state_d = ST_BREAD;
        end
      end
      ST_BREAD: begin
        pop_en  = 1'b1;
        push_en = 1'b1;
        push_lv = 2'd0;
        push_p  = frd_q;
        state_d = ST_BMOVE;
      end
      ST_BBLK: begin
        if (i_q >= bc_q) state_d = ST_REL;
      end
      ST_REL: begin
        alu_a = rem_q[rel_own];
        alu_b = 16'(len_q[c_q]);
        if (!rel_skip) state_d = ST_RELB;
        else if (c_q) state_d = ST_RMARK;
      end
      ST_RELB: begin
        if (rem_zero) begin
          if (has_io) begin
            bre = 1'b1;
            state_d = ST_RIO;
          end else begin
            emit_o.valid = 1'b1;
            emit_o.kind  = KIND_FINISH;
            emit_o.pid   = pid_q[cur_q];
            emit_o.inst  = slc_q[cur_q];
            emit_o.cpu   = c_q;
            emit_o.st    = arr_q[cur_q];
            emit_o.en    = end_q[c_q];
            if (emit_ok_i) state_d = c_q ? ST_RMARK : ST_REL;
          end
        end else begin
          push_en = 1'b1;
          push_lv = new_lvl;
          push_p  = cur_q;
          state_d = c_q ? ST_RMARK : ST_REL;
        end
      end
      ST_RIO: begin
        alu_op = ALU_ADD_SAT;
        alu_a  = end_q[c_q];
        alu_b  = brd_q;
        if (has_next) begin
          bre = 1'b1;
          bra = baddr(cur_q, pos2);
          state_d = ST_RIO2;
        end else begin
          state_d = c_q ? ST_RMARK : ST_REL;
        end
      end
      ST_RIO2: state_d = c_q ? ST_RMARK : ST_REL;
      ST_RMARK: state_d = ST_RSCAN;
      ST_RSCAN: begin
        if (i_q >= bc_q) state_d = found_q ? ST_RPUSH : ST_RCMP;
      end
      ST_RPUSH: begin
        push_en = 1'b1;
        push_lv = lvl_q[best_p];
        push_p  = best_p;
        state_d = ST_RSCAN;
      end
      ST_RCMP: begin
        if (i_q >= bc_q) state_d = ST_ADMIT;
      end
      ST_ADMIT: begin
        if ((nxt_q < pc_q) && (arr_q[nxt_i] <= now_q)) begin
          push_en = 1'b1;
          push_lv = 2'd0;
          push_p  = nxt_i;
        end else begin
          state_d = ST_ASSIGN;
        end
      end
      ST_ASSIGN: begin
        if (busy_q[c_q]) begin
          if (c_q) state_d = ST_JUMP;
        end else if (!asn_any) begin
          state_d = ST_JUMP;
        end else begin
          fre = 1'b1;
          fra = faddr(asn_lv, head_q[asn_lv]);
          state_d = ST_ASNRD;
        end
      end
      ST_ASNRD: begin
        alu_op = ALU_ADD_SAT;
        alu_a  = now_q;
        alu_b  = 16'(run);
        emit_o.valid = 1'b1;
        emit_o.kind  = KIND_SLICE;
        emit_o.pid   = pid_q[asn_p];
        emit_o.inst  = slc_new;
        emit_o.cpu   = c_q;
        emit_o.st    = now_q;
        emit_o.en    = alu_res;
        pop_en = emit_ok_i;
        if (emit_ok_i) state_d = c_q ? ST_JUMP : ST_ASSIGN;
      end
      ST_JUMP: state_d = ST_JBLK;
      ST_JBLK: begin
        if (i_q >= bc_q) state_d = ST_STATUS;
      end
      ST_STATUS: begin
        emit_o.valid = 1'b1;
        emit_o.kind  = ovf_q ? KIND_ERROR : ((done_q >= pc_q) ? KIND_DONE : KIND_PENDING);
        emit_o.st    = t0_q;
        emit_o.en    = now_q;
        emit_o.last  = 1'b1;
        if (emit_ok_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (bwe) bmem[bwa] <= it_q.len;
    if (bre) brd_q <= bmem[bra];
    if (push_en && (cnt_q[push_lv] < CW'(MAX_PROCS)))
      fmem[faddr(push_lv, tail_of(head_q[push_lv], cnt_q[push_lv]))] <= push_p;
    if (fre) frd_q <= fmem[fra];
  end

  // process tables and blocked list
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_LOAD: begin
        if (emit_ok_i && ld_ok) begin
          if (!open_q) begin
            pid_q[ld_pi]  <= it_q.pid;
            arr_q[ld_pi]  <= it_q.arr;
            bcnt_q[ld_pi] <= BCW'(1);
            bpos_q[ld_pi] <= '0;
            lvl_q[ld_pi]  <= 2'd0;
            slc_q[ld_pi]  <= '0;
            rem_q[ld_pi]  <= it_q.len;
            iod_q[ld_pi]  <= '0;
          end else begin
            bcnt_q[ld_pi] <= ld_c + BCW'(1);
          end
        end
      end
      ST_BREAD: lvl_q[frd_q] <= 2'd0;
      ST_BBLK: begin
        if (i_q < bc_q) lvl_q[blk_i] <= 2'd0;
      end
      ST_REL: begin
        if (!rel_skip) rem_q[rel_own] <= alu_res;
      end
      ST_RELB: begin
        if (rem_zero && !has_io && emit_ok_i) bpos_q[cur_q] <= BCW'(pos1);
        if (!rem_zero) lvl_q[cur_q] <= new_lvl;
      end
      ST_RIO: begin
        iod_q[cur_q] <= alu_res;
        if (!has_next) begin
          bpos_q[cur_q] <= BCW'(pos2);
          if (bc_q < CW'(MAX_PROCS)) blk_q[PW'(bc_q)] <= cur_q;
        end
      end
      ST_RIO2: begin
        rem_q[cur_q]  <= brd_q;
        bpos_q[cur_q] <= BCW'(pos2);
        if (bc_q < CW'(MAX_PROCS)) blk_q[PW'(bc_q)] <= cur_q;
      end
      ST_RCMP: begin
        if ((i_q < bc_q) && !gone_q[PW'(i_q)]) blk_q[PW'(j_q)] <= blk_i;
      end
      ST_ASNRD: begin
        if (emit_ok_i) slc_q[asn_p] <= slc_new;
      end
      default: ;
    endcase
  end

  // control, queue pointers and CPU state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NumLevels; l++) begin
        head_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
      bc_q    <= '0;
      busy_q  <= '0;
      now_q   <= '0;
      lastb_q <= '0;
      nxt_q   <= '0;
      pc_q    <= '0;
      done_q  <= '0;
      open_q  <= 1'b0;
      ovf_q   <= 1'b0;
      found_q <= 1'b0;
      c_q     <= 1'b0;
      lv_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      best_q  <= '0;
      rdy_q   <= '0;
      gone_q  <= '0;
    end else begin
      for (int l = 0; l < NumLevels; l++) begin
        if (push_en && (push_lv == 2'(l)) && (cnt_q[l] < CW'(MAX_PROCS))) begin
          cnt_q[l] <= cnt_q[l] + CW'(1);
        end
        if (pop_en && (pop_lv == 2'(l))) begin
          head_q[l] <= head_inc(head_q[l]);
          cnt_q[l]  <= cnt_q[l] - CW'(1);
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc_i) begin
            it_q  <= item_i;
            t0_q  <= now_q;
            ovf_q <= 1'b0;
            c_q   <= 1'b0;
          end
        end
        ST_LOAD: begin
          if (emit_ok_i && ld_ok) begin
            if (!open_q) open_q <= 1'b1;
            if (it_q.fin) begin
              open_q <= 1'b0;
              pc_q   <= pc_q + CW'(1);
            end
          end
        end
        ST_BOOST: begin
          if ((boost_i != '0) && (now_q != '0) && (alu_res >= boost_i)) begin
            lastb_q <= now_q;
            lv_q    <= 2'd1;
          end
        end
        ST_BMOVE: begin
          if ((cnt_q[lv_q] == '0) && (lv_q == 2'd1)) lv_q <= 2'd2;
          i_q <= '0;
        end
        ST_BBLK: begin
          i_q <= i_q + CW'(1);
          c_q <= 1'b0;
        end
        ST_REL: begin
          cur_q <= rel_own;
          if (rel_skip) c_q <= 1'b1;
        end
        ST_RELB: begin
          if (rem_zero && !has_io && emit_ok_i) begin
            done_q       <= done_q + CW'(1);
            busy_q[c_q]  <= 1'b0;
            end_q[c_q]   <= now_q;
            c_q          <= 1'b1;
          end
          if (!rem_zero) begin
            busy_q[c_q] <= 1'b0;
            end_q[c_q]  <= now_q;
            c_q         <= 1'b1;
          end
        end
        ST_RIO: begin
          ovf_q <= ovf_q | alu_ovf;
          if (!has_next) begin
            if (bc_q < CW'(MAX_PROCS)) bc_q <= bc_q + CW'(1);
            busy_q[c_q] <= 1'b0;
            end_q[c_q]  <= now_q;
            c_q         <= 1'b1;
          end
        end
        ST_RIO2: begin
          if (bc_q < CW'(MAX_PROCS)) bc_q <= bc_q + CW'(1);
          busy_q[c_q] <= 1'b0;
          end_q[c_q]  <= now_q;
          c_q         <= 1'b1;
        end
        ST_RMARK: begin
          for (int k = 0; k < MAX_PROCS; k++) begin
            rdy_q[k]  <= (CW'(k) < bc_q) && (iod_q[blk_q[k]] <= now_q);
            gone_q[k] <= (CW'(k) < bc_q) && (iod_q[blk_q[k]] <= now_q);
          end
          i_q     <= '0;
          found_q <= 1'b0;
        end
        ST_RSCAN: begin
          if (i_q < bc_q) begin
            if (rdy_q[PW'(i_q)] && (!found_q || (pid_q[blk_i] < bestpid_q))) begin
              best_q    <= i_q;
              bestpid_q <= pid_q[blk_i];
              found_q   <= 1'b1;
            end
            i_q <= i_q + CW'(1);
          end else begin
            i_q <= '0;
            j_q <= '0;
          end
        end
        ST_RPUSH: begin
          rdy_q[PW'(best_q)] <= 1'b0;
          i_q     <= '0;
          found_q <= 1'b0;
        end
        ST_RCMP: begin
          if (i_q < bc_q) begin
            if (!gone_q[PW'(i_q)]) j_q <= j_q + CW'(1);
            i_q <= i_q + CW'(1);
          end else begin
            bc_q <= j_q;
          end
        end
        ST_ADMIT: begin
          if ((nxt_q < pc_q) && (arr_q[nxt_i] <= now_q)) nxt_q <= nxt_q + CW'(1);
          c_q <= 1'b0;
        end
        ST_ASSIGN: begin
          if (busy_q[c_q]) c_q <= 1'b1;
          else lv_q <= asn_lv;
        end
        ST_ASNRD: begin
          if (emit_ok_i) begin
            busy_q[c_q] <= 1'b1;
            own_q[c_q]  <= asn_p;
            len_q[c_q]  <= run;
            end_q[c_q]  <= alu_res;
            ovf_q       <= ovf_q | alu_ovf;
            c_q         <= 1'b1;
          end
        end
        ST_JUMP: begin
          logic        f;
          logic [15:0] t;
          f = 1'b0;
          t = '0;
          for (int k = 0; k < 2; k++) begin
            if (busy_q[k] && (!f || (end_q[k] < t))) begin
              t = end_q[k];
              f = 1'b1;
            end
          end
          if ((nxt_q < pc_q) && (!f || (arr_q[nxt_i] < t))) begin
            t = arr_q[nxt_i];
            f = 1'b1;
          end
          tmin_q  <= t;
          found_q <= f;
          i_q     <= '0;
        end
        ST_JBLK: begin
          if (i_q < bc_q) begin
            if (!found_q || (iod_q[blk_i] < tmin_q)) begin
              tmin_q  <= iod_q[blk_i];
              found_q <= 1'b1;
            end
            i_q <= i_q + CW'(1);
          end else if (found_q && (tmin_q > now_q)) begin
            now_q <= tmin_q;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/mlfq_dual_cpu_scheduler.sv @@
// Top level: stream ports, boost interval register and result output register.
//
//   channel   dir  handshake                   payload
//   s_axis    in   s_axis_tvalid/tready        tuser op, tdata item, tlast final burst
//   m_axis    out  m_axis_tvalid/tready        tuser kind, tdata record, tlast last word
//   cfg       in   cfg_valid_i/cfg_ready_o     cfg_data_i boost interval
//
// A load word is taken in ST_IDLE and answered in ST_LOAD. A step runs longer as Q,
// the number of queue entries moved by a boost, and B, the blocked-list length, grow:
// the single sequencer walks the blocked list once per I/O return it selects.
// After reset all queues are empty and both CPUs idle; no clearing pass is run.
// A full output register stalls the sequencer at the next record it emits.
`default_nettype none
module mlfq_dual_cpu_scheduler
  import mdcs_pkg::*;
#(
  parameter int MAX_PROCS     = MaxProcsDef,
  parameter int MAX_BURSTS    = MaxBurstsDef,
  parameter int SLICE_QUANTUM = QuantumDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // proc_id[7:0], arrival[23:8], burst_length[39:24]
  input  logic [39:0] s_axis_tdata,
  // operation[0]
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_proc_id[7:0], run_instance[15:8], cpu_index[16], slice_start[32:17],
  // slice_end[48:33], zero[55:49]
  output logic [55:0] m_axis_tdata,
  // kind[2:0]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] boost_q;
  logic        out_valid_q;
  emit_t       out_q;
  emit_t       emit;
  item_t       item;
  logic        seq_ready, emit_ok, in_acc;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = seq_ready;
  assign in_acc        = s_axis_tvalid && seq_ready;
  assign emit_ok       = !out_valid_q || m_axis_tready;

  assign item.op  = s_axis_tuser;
  assign item.pid = s_axis_tdata[7:0];
  assign item.arr = s_axis_tdata[23:8];
  assign item.len = s_axis_tdata[39:24];
  assign item.fin = s_axis_tlast;

  mdcs_seq #(
    .MAX_PROCS     (MAX_PROCS),
    .MAX_BURSTS    (MAX_BURSTS),
    .SLICE_QUANTUM (SLICE_QUANTUM)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_acc_i  (in_acc),
    .item_i    (item),
    .boost_i   (boost_q),
    .emit_ok_i (emit_ok),
    .ready_o   (seq_ready),
    .emit_o    (emit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boost_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) boost_q <= cfg_data_i;
      // hold the word until taken, load a new one when the slot frees
      if (emit_ok) out_valid_q <= emit.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ok && emit.valid) out_q <= emit;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {7'd0, out_q.en, out_q.st, out_q.cpu, out_q.inst, out_q.pid};

endmodule
`default_nettype wire

@@ bench/mdcs_schedule_checker.sv @@
// Watches the scheduler's streams, predicts every record and compares what comes out.
`timescale 1ns / 1ps
module mdcs_schedule_checker
  import mdcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [39:0] s_tdata_i,
  input  logic        s_tuser_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [55:0] m_tdata_i,
  input  logic [2:0]  m_tuser_i,
  input  logic        m_tlast_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int          mismatches_o,
  output int          waiting_o,
  output logic        all_done_o
);

  localparam int NP = MaxProcsDef;
  localparam int NB = MaxBurstsDef;
  localparam int QT = QuantumDef;
  localparam int NL = NumLevels;
  localparam int QD = 64;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pid;
    logic [7:0]  inst;
    logic        cpu;
    logic [15:0] st;
    logic [15:0] en;
    logic        last;
  } rec_t;

  rec_t want_mem[QD];
  int   wr_cnt = 0;
  int   rd_cnt = 0;
  int   mism = 0;

  logic [15:0] boost_iv = '0;
  logic [7:0]  pids[NP];
  logic [15:0] arr_t[NP];
  logic [15:0] bursts[NP][NB];
  int          bcnt[NP];
  int          bpos[NP];
  logic [15:0] rem[NP];
  int          lvl[NP];
  logic [15:0] io_t[NP];
  int          scnt[NP];
  int          fifo[NL][NP];
  int          fhead[NL];
  int          fcnt[NL];
  int          blk[NP];
  int          nblk = 0;
  bit          busy[2];
  int          owner[2];
  logic [15:0] cend[2];
  logic [15:0] clen[2];
  logic [15:0] now_t = '0;
  logic [15:0] lboost = '0;
  int          nxt = 0;
  int          nproc = 0;
  int          ndone = 0;
  bit          open_proc = 0;
  bit          time_ovf;

  initial begin
    for (int i = 0; i < NP; i++) begin
      pids[i] = '0; arr_t[i] = '0; rem[i] = '0; io_t[i] = '0;
      bcnt[i] = 0; bpos[i] = 0; lvl[i] = 0; scnt[i] = 0; blk[i] = 0;
      for (int j = 0; j < NB; j++) bursts[i][j] = '0;
    end
    for (int l = 0; l < NL; l++) begin
      fhead[l] = 0; fcnt[l] = 0;
      for (int i = 0; i < NP; i++) fifo[l][i] = 0;
    end
    for (int c = 0; c < 2; c++) begin
      busy[c] = 0; owner[c] = 0; cend[c] = '0; clen[c] = '0;
    end
  end

  function automatic void push_rec(kind_e k, logic [7:0] pid, logic [7:0] inst, logic cpu,
                                   logic [15:0] st, logic [15:0] en, logic last);
    rec_t r;
    r.kind = k; r.pid = pid; r.inst = inst; r.cpu = cpu; r.st = st; r.en = en; r.last = last;
    want_mem[wr_cnt % QD] = r;
    wr_cnt++;
  endfunction

  function automatic void lvl_push(int lv, int p);
    if (lv >= NL || fcnt[lv] >= NP) return;
    fifo[lv][(fhead[lv] + fcnt[lv]) % NP] = p;
    fcnt[lv]++;
  endfunction

  function automatic int lvl_pop(int lv);
    int p;
    p = fifo[lv][fhead[lv]];
    fhead[lv] = (fhead[lv] + 1) % NP;
    fcnt[lv]--;
    return p;
  endfunction

  function automatic logic [15:0] sat16(int a, int b);
    int s;
    s = a + b;
    if (s > 65535) begin
      time_ovf = 1;
      return 16'hFFFF;
    end
    return s[15:0];
  endfunction

  function automatic bit load_burst(logic [7:0] pid, logic [15:0] a, logic [15:0] len, bit fin);
    int p;
    int c;
    p = nproc;
    if (len == 0) return 0;
    if (!open_proc) begin
      if (p >= NP) return 0;
      if (p > 0 && a < arr_t[p-1]) return 0;
      pids[p] = pid; arr_t[p] = a; bpos[p] = 0; lvl[p] = 0; scnt[p] = 0;
      rem[p] = len; io_t[p] = '0; bursts[p][0] = len; bcnt[p] = 1;
      open_proc = 1;
    end else begin
      c = bcnt[p];
      if (c >= NB) return 0;
      // a final burst may not sit at an I/O position
      if (fin && c[0]) return 0;
      bursts[p][c] = len;
      bcnt[p] = c + 1;
    end
    if (fin) begin
      open_proc = 0;
      nproc++;
    end
    return 1;
  endfunction

  task automatic schedule_step();
    logic [15:0] t0;
    logic [15:0] t;
    int p, pos, run, nret, keep, j, lv;
    int ret[NP];
    bit found;
    kind_e k;
    time_ovf = 0;
    t0 = now_t;
    if (ndone < nproc) begin
      if (boost_iv > 0 && now_t > 0 && (int'(now_t) - int'(lboost)) >= int'(boost_iv)) begin
        lboost = now_t;
        for (int l = 1; l < NL; l++) begin
          while (fcnt[l] > 0) begin
            p = lvl_pop(l);
            lvl[p] = 0;
            lvl_push(0, p);
          end
        end
        for (int i = 0; i < nblk; i++) lvl[blk[i]] = 0;
      end

      // release expired slices
      for (int c = 0; c < 2; c++) begin
        if (!busy[c] || cend[c] > now_t) continue;
        p = owner[c];
        rem[p] = rem[p] - clen[c];
        if (rem[p] == 0) begin
          pos = bpos[p] + 1;
          if (pos < bcnt[p] && pos < NB) begin
            io_t[p] = sat16(cend[c], bursts[p][pos]);
            pos++;
            if (pos < bcnt[p] && pos < NB) rem[p] = bursts[p][pos];
            bpos[p] = pos;
            if (nblk < NP) begin
              blk[nblk] = p;
              nblk++;
            end
          end else begin
            bpos[p] = pos;
            ndone++;
            push_rec(KIND_FINISH, pids[p], 8'(scnt[p]), c[0], arr_t[p], cend[c], 1'b0);
          end
        end else begin
          if (lvl[p] < NL - 1) lvl[p]++;
          lvl_push(lvl[p], p);
        end
        busy[c] = 0;
        cend[c] = now_t;
      end

      // I/O returns sorted by pid, stable on ties
      nret = 0;
      keep = 0;
      for (int i = 0; i < nblk; i++) begin
        p = blk[i];
        if (io_t[p] <= now_t) begin
          j = nret;
          while (j > 0 && pids[ret[j-1]] > pids[p]) begin
            ret[j] = ret[j-1];
            j--;
          end
          ret[j] = p;
          nret++;
        end else begin
          blk[keep] = p;
          keep++;
        end
      end
      nblk = keep;
      for (int i = 0; i < nret; i++) lvl_push(lvl[ret[i]], ret[i]);

      while (nxt < nproc && arr_t[nxt] <= now_t) begin
        lvl_push(0, nxt);
        nxt++;
      end

      for (int c = 0; c < 2; c++) begin
        if (busy[c]) continue;
        lv = 0;
        while (lv < NL && fcnt[lv] == 0) lv++;
        if (lv >= NL) break;
        p = lvl_pop(lv);
        run = (rem[p] < QT) ? int'(rem[p]) : QT;
        if (scnt[p] < 255) scnt[p]++;
        busy[c] = 1;
        owner[c] = p;
        clen[c] = run[15:0];
        cend[c] = sat16(now_t, run);
        push_rec(KIND_SLICE, pids[p], 8'(scnt[p]), c[0], now_t, cend[c], 1'b0);
      end

      // jump to the earliest pending event
      found = 0;
      t = '0;
      for (int c = 0; c < 2; c++) begin
        if (busy[c] && (!found || cend[c] < t)) begin
          t = cend[c];
          found = 1;
        end
      end
      if (nxt < nproc && (!found || arr_t[nxt] < t)) begin
        t = arr_t[nxt];
        found = 1;
      end
      for (int i = 0; i < nblk; i++) begin
        if (!found || io_t[blk[i]] < t) begin
          t = io_t[blk[i]];
          found = 1;
        end
      end
      if (found && t > now_t) now_t = t;
    end
    k = time_ovf ? KIND_ERROR : ((ndone >= nproc) ? KIND_DONE : KIND_PENDING);
    push_rec(k, 8'd0, 8'd0, 1'b0, t0, now_t, 1'b1);
  endtask

  always @(posedge clk_i) begin
    rec_t got;
    rec_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) boost_iv = cfg_data_i;
      // compare first: a word leaving now cannot stem from one entering now
      if (m_tvalid_i && m_tready_i) begin
        got.kind = kind_e'(m_tuser_i);
        got.pid  = m_tdata_i[7:0];
        got.inst = m_tdata_i[15:8];
        got.cpu  = m_tdata_i[16];
        got.st   = m_tdata_i[32:17];
        got.en   = m_tdata_i[48:33];
        got.last = m_tlast_i;
        if (wr_cnt == rd_cnt) begin
          mism++;
          if (mism <= 10) $display("unexpected record: kind %0d pid %0d", got.kind, got.pid);
        end else begin
          want = want_mem[rd_cnt % QD];
          rd_cnt++;
          if (got !== want) begin
            mism++;
            if (mism <= 10) begin
              $display("mismatch: exp kind %0d pid %0d inst %0d cpu %0d st %0d en %0d last %0d",
                       want.kind, want.pid, want.inst, want.cpu, want.st, want.en, want.last);
              $display("          got kind %0d pid %0d inst %0d cpu %0d st %0d en %0d last %0d",
                       got.kind, got.pid, got.inst, got.cpu, got.st, got.en, got.last);
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i) schedule_step();
        else
          push_rec(load_burst(s_tdata_i[7:0], s_tdata_i[23:8], s_tdata_i[39:24], s_tlast_i)
                   ? KIND_LOAD_OK : KIND_ERROR, s_tdata_i[7:0], 8'd0, 1'b0, 16'd0, 16'd0, 1'b1);
      end
    end
    mismatches_o <= mism;
    waiting_o    <= wr_cnt - rd_cnt;
    all_done_o   <= (ndone >= nproc);
  end

endmodule

@@ bench/mlfq_dual_cpu_scheduler_test.sv @@
// Stimulus and verdict for the two-CPU feedback-queue scheduler.
`timescale 1ns / 1ps
module mlfq_dual_cpu_scheduler_test;
  import mdcs_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [55:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int          mism;
  int          waiting;
  logic        all_done;
  int          idle_pct = 26;
  int          stall_pct = 63;
  logic [15:0] last_arr = '0;

  mlfq_dual_cpu_scheduler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  mdcs_schedule_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tlast_i    (m_tlast),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mism),
    .waiting_o    (waiting),
    .all_done_o   (all_done)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk_i) m_tready <= ($urandom_range(99) >= stall_pct);

  task automatic send_word(bit op, logic [7:0] pid, logic [15:0] a, logic [15:0] len, bit fin);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk_i);
    end
    s_tvalid <= 1;
    s_tuser  <= op;
    s_tdata  <= {len, a, pid};
    s_tlast  <= fin;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  // steps carry random content, which the block ignores
  task automatic step_word();
    send_word(1'b1, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic settle();
    s_tvalid <= 0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
  endtask

  task automatic write_boost(logic [15:0] v);
    settle();
    repeat (10) @(posedge clk_i);
    cfg_valid <= 1;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 0;
  endtask

  task automatic run_until_done();
    int n;
    n = 0;
    do begin
      repeat (3) step_word();
      settle();
      n++;
    end while (!all_done && n < 400);
    // one more step with nothing left to do
    step_word();
  endtask

  task automatic load_process(logic [7:0] pid, logic [15:0] a, int nb, int cpu_max, bit long_cpu);
    logic [15:0] len;
    for (int i = 0; i < nb; i++) begin
      if (i % 2 == 1 && $urandom_range(9) == 0)
        send_word(1'b0, 8'($urandom), 16'($urandom), 16'($urandom_range(65535, 1)), 1'b1);
      if ($urandom_range(14) == 0)
        send_word(1'b0, pid, a, 16'd0, 1'($urandom_range(1)));
      if (i % 2 == 0) len = long_cpu ? 16'd24 : 16'($urandom_range(cpu_max, 1));
      else if ($urandom_range(7) == 0) len = 16'($urandom_range(65535, 1));
      else len = 16'($urandom_range(12, 1));
      if (i == 0) send_word(1'b0, pid, a, len, nb == 1);
      else send_word(1'b0, 8'($urandom), 16'($urandom), len, i == nb - 1);
    end
  endtask

  task automatic run_round(int nprocs, int pid_span, int cpu_max, bit with_long);
    int a;
    for (int k = 0; k < nprocs; k++) begin
      a = int'(last_arr) + $urandom_range(6);
      if (a > 65535) a = 65535;
      if (last_arr > 0 && $urandom_range(4) == 0)
        send_word(1'b0, 8'($urandom), last_arr - 16'd1, 16'($urandom_range(65535, 1)), 1'b1);
      load_process(8'($urandom_range(pid_span)), a[15:0], 2 * $urandom_range(3) + 1, cpu_max,
                   with_long && k == 0);
      last_arr = a[15:0];
    end
    run_until_done();
  endtask

  initial begin
    int n;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    repeat (2) @(posedge clk_i);
    write_boost(16'd0);

    // zero burst, final I/O burst, then two small processes and a bad arrival order
    send_word(1'b0, 8'hFF, 16'd0, 16'd0, 1'b1);
    send_word(1'b0, 8'hFF, 16'd0, 16'd3, 1'b0);
    send_word(1'b0, 8'h00, 16'hFFFF, 16'd4, 1'b1);
    send_word(1'b0, 8'h00, 16'hFFFF, 16'd1, 1'b0);
    send_word(1'b0, 8'h12, 16'h1234, 16'd2, 1'b1);
    send_word(1'b0, 8'h00, 16'd3, 16'd1, 1'b1);
    send_word(1'b0, 8'h55, 16'd2, 16'd5, 1'b1);
    last_arr = 16'd3;
    run_until_done();

    run_round(3, 255, 4, 1'b0);
    write_boost(16'd1);
    run_round(3, 3, 5, 1'b0);
    idle_pct  = 63;
    stall_pct = 26;
    write_boost(16'hFFFF);
    run_round(3, 255, 3, 1'b0);
    write_boost(16'($urandom));
    run_round(3, 255, 3, 1'b1);
    idle_pct  = 0;
    stall_pct = 0;
    write_boost(16'd3);

    // push slice ends and I/O returns past the top of the time range
    send_word(1'b0, 8'hA5, 16'd65533, 16'd5, 1'b0);
    send_word(1'b0, 8'hA5, 16'd65533, 16'd10, 1'b0);
    send_word(1'b0, 8'hA5, 16'd65533, 16'd3, 1'b1);
    send_word(1'b0, 8'h5A, 16'hFFFF, 16'd1, 1'b1);
    run_until_done();
    // table is full now
    send_word(1'b0, 8'h12, 16'hFFFF, 16'd7, 1'b1);
    step_word();

    s_tvalid <= 0;
    n = 0;
    @(posedge clk_i);
    while (waiting != 0 && n < 200000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (50) @(posedge clk_i);
    if (mism == 0 && waiting == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
